// ----- design/i8mvm_pkg.sv -----
package i8mvm_pkg;

   localparam int MAX_COLUMNS = 16;
   localparam int MAX_DEPTH   = 256;

   // column number, weight address, column count, element position
   localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int DEPTH_AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W    = $clog2(MAX_COLUMNS + 1);
   localparam int PCNT_W   = $clog2(MAX_DEPTH + 1);

   localparam logic [4:0] COLS_RESET = 5'd16;

   // one beat travelling down the cell chain
   typedef struct packed {
      logic                valid;
      logic                wr;        // weight write
      logic                mac;       // accumulate this element
      logic                last;      // row end: capture and clear
      logic [COL_W-1:0]    column;
      logic [DEPTH_AW-1:0] position;
      logic signed [7:0]   value;
      logic [CNT_W-1:0]    ncols;
   } token_type;

endpackage

// ----- design/int8_matrix_vector_mac_unit.sv -----
// int8 weight-stationary matrix-vector MAC, C = A * B^T, one result row at a time.
// Request channel (req_*, valid/ready): action 0 loads one signed weight byte into
// column req_weight_column at position req_weight_position; action 1 streams one
// activation element, req_row_end marking the last element of the row.
// Response channel (rsp_*, valid/ready): at each row end one int32 sum per active
// column, in column order, rsp_final_column on the last, rsp_depth_overflow if any
// element of the row went past the depth limit and was dropped.
// csr_write_enable/csr_write_data set the active column count (reset 16).
// Throughput: weight beats and non-final elements are taken one per cycle. The
// element beat travels down a chain of one cell per column, a cell per cycle,
// each cell reading its own weight memory and accumulating one product.
// After a row end the input stalls: the row-end beat walks on to clear the last
// cell, then the sums shift out of the chain one per cycle unless the receiver
// stalls, and the input reopens when the last sum sits in the output register.
// A stalled receiver holds the output register and freezes the drain shift.
// Reset (synchronous) clears accumulators, position, overflow flag, column count
// and all control; weight memories are not cleared and must be written first.
module int8_matrix_vector_mac_unit
   import i8mvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [3:0]         req_weight_column,
   input  logic [7:0]         req_weight_position,
   input  logic signed [7:0]  req_element_value,
   input  logic               req_row_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_dot_sum,
   output logic [3:0]         rsp_column_index,
   output logic               rsp_final_column,
   output logic               rsp_depth_overflow,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);

   localparam logic [1:0] ST_RUN   = 2'd0;   // taking beats
   localparam logic [1:0] ST_WAIT  = 2'd1;   // row end in the chain
   localparam logic [1:0] ST_DRAIN = 2'd2;   // shifting sums out

   logic [1:0]         state_ff, state_in;
   logic [4:0]         cols_ff;
   logic [CNT_W-1:0]   ncols;
   logic [PCNT_W-1:0]  pos_ff, pos_in;
   logic               ovf_ff, ovf_in;
   logic               row_ovf_ff, row_ovf_in;
   logic [CNT_W-1:0]   drain_n_ff, drain_n_in;
   logic [COL_W-1:0]   cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_sum_ff;
   logic [3:0]         rsp_col_ff;
   logic               rsp_final_ff;
   logic               rsp_ovf_ff;

   logic               accept;
   logic               in_range;
   logic               wr_ok;
   logic               out_load;
   logic               drain_last;
   token_type          entry;

   token_type          tok  [MAX_COLUMNS+1];
   logic signed [31:0] sums [MAX_COLUMNS+1];
   logic               done [MAX_COLUMNS];

   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;

   // column count register
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
      end else if (csr_write_enable) begin
         cols_ff <= csr_write_data;
      end
   end

   // zero counts as one, anything above the chain length as the chain length
   always_comb begin
      if (cols_ff == 5'd0) begin
         ncols = CNT_W'(1);
      end else if (32'(cols_ff) > MAX_COLUMNS) begin
         ncols = CNT_W'(MAX_COLUMNS);
      end else begin
         ncols = CNT_W'(cols_ff);
      end
   end

   // entry beat into the first cell
   always_comb begin
      in_range = 32'(pos_ff) < MAX_DEPTH;
      wr_ok    = (32'(req_weight_column) < MAX_COLUMNS)
               && (32'(req_weight_position) < MAX_DEPTH);
      entry          = '0;
      entry.value    = req_element_value;
      entry.ncols    = ncols;
      entry.column   = COL_W'(req_weight_column);
      if (!req_action) begin
         entry.valid    = accept && wr_ok;
         entry.wr       = 1'b1;
         entry.position = DEPTH_AW'(req_weight_position);
      end else begin
         // dropped element still carries a row end through the chain
         entry.valid    = accept && (in_range || req_row_end);
         entry.mac      = in_range;
         entry.last     = req_row_end;
         entry.position = DEPTH_AW'(pos_ff);
      end
   end

   assign tok[0] = entry;
   assign sums[MAX_COLUMNS] = '0;

   for (genvar j = 0; j < MAX_COLUMNS; j++) begin : g_cell
      i8mvm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (COL_W'(j)),
         .tok_i      (tok[j]),
         .tok_o      (tok[j+1]),
         .shift      (out_load),
         .sum_next_i (sums[j+1]),
         .sum_o      (sums[j]),
         .row_done_o (done[j])
      );
   end

   assign out_load   = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign drain_last = (CNT_W'(cnt_ff) + CNT_W'(1)) == drain_n_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      row_ovf_in   = row_ovf_ff;
      drain_n_in   = drain_n_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_RUN: begin
            if (accept && req_action) begin
               if (in_range) begin
                  pos_in = pos_ff + PCNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_row_end) begin
                  row_ovf_in = ovf_ff || !in_range;
                  drain_n_in = ncols;
                  pos_in     = '0;
                  ovf_in     = 1'b0;
                  state_in   = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (done[MAX_COLUMNS-1]) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               cnt_in       = cnt_ff + COL_W'(1);
               if (drain_last) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         row_ovf_ff   <= 1'b0;
         drain_n_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         row_ovf_ff   <= row_ovf_in;
         drain_n_ff   <= drain_n_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output beat register, loaded from the head of the chain
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sum_ff   <= sums[0];
         rsp_col_ff   <= 4'(cnt_ff);
         rsp_final_ff <= drain_last;
         rsp_ovf_ff   <= row_ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dot_sum        = rsp_sum_ff;
   assign rsp_column_index   = rsp_col_ff;
   assign rsp_final_column   = rsp_final_ff;
   assign rsp_depth_overflow = rsp_ovf_ff;

   // row end accepted always parks the input in the wait state
   a_row_end_wait: assert property (@(posedge clock) disable iff (reset)
      accept && req_action && req_row_end |=> state_ff == ST_WAIT)
      else $error("row end did not stop the input");

   // the row-end beat only leaves the chain while waiting for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      done[MAX_COLUMNS-1] |-> state_ff == ST_WAIT)
      else $error("row end left the chain outside the wait state");

   // a non-final sum means more are still to come
   a_more_to_come: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_final_ff |-> state_ff == ST_DRAIN)
      else $error("drain ended before the final column");

   // sums of a row come in column order, without gaps
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !rsp_final_ff
      |=> rsp_valid_ff && (rsp_col_ff == 4'($past(rsp_col_ff) + 4'd1)))
      else $error("column order broken");

endmodule

// ----- design/i8mvm_cell.sv -----
module i8mvm_cell
   import i8mvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COL_W-1:0]   cell_index,
   input  token_type          tok_i,
   output token_type          tok_o,
   input  logic               shift,
   input  logic signed [31:0] sum_next_i,
   output logic signed [31:0] sum_o,
   output logic               row_done_o
);

   logic signed [7:0]  mem [MAX_DEPTH];
   logic signed [7:0]  rd_ff;
   token_type          tok_ff;
   token_type          s2_ff;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [31:0] acc_sum;
   logic signed [15:0] prod;
   logic               active;
   logic               wr_en;

   assign wr_en = tok_ff.valid && tok_ff.wr && (tok_ff.column == cell_index);

   // weight column store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tok_ff.position] <= tok_ff.value;
      end
      rd_ff <= mem[tok_ff.position];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         s2_ff  <= '0;
      end else begin
         tok_ff <= tok_i;
         s2_ff  <= tok_ff;
      end
   end

   always_comb begin
      active  = s2_ff.valid && (CNT_W'(cell_index) < s2_ff.ncols);
      prod    = 16'(s2_ff.value) * 16'(rd_ff);
      acc_sum = acc_ff;
      if (active && s2_ff.mac) begin
         acc_sum = acc_ff + {{16{prod[15]}}, prod};
      end
      sum_in = sum_ff;
      if (s2_ff.valid && s2_ff.last) begin
         sum_in = acc_sum;
         acc_in = '0;
      end else begin
         acc_in = acc_sum;
         if (shift) begin
            sum_in = sum_next_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign tok_o      = tok_ff;
   assign sum_o      = sum_ff;
   assign row_done_o = s2_ff.valid && s2_ff.last;

endmodule

// ----- tb/i8mvm_tb_pkg.sv -----
package i8mvm_tb_pkg;

   // request beat kinds
   typedef enum logic {
      ACTION_WEIGHT  = 1'b0,
      ACTION_ELEMENT = 1'b1
   } action_type;

endpackage

// ----- tb/i8mvm_checker.sv -----
module i8mvm_checker
   import i8mvm_pkg::*;
   import i8mvm_tb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_action,
   input  logic [3:0]         req_weight_column,
   input  logic [7:0]         req_weight_position,
   input  logic signed [7:0]  req_element_value,
   input  logic               req_row_end,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_dot_sum,
   input  logic [3:0]         rsp_column_index,
   input  logic               rsp_final_column,
   input  logic               rsp_depth_overflow,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   output int                 sums_pending,
   output int                 fault_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [31:0] dot_sum;
      logic [3:0]         column_index;
      logic               final_column;
      logic               depth_overflow;
   } column_sum_type;

   logic signed [7:0] weight_mem [MAX_COLUMNS][MAX_DEPTH];
   logic [31:0]       col_acc [MAX_COLUMNS];
   logic [PCNT_W-1:0] elem_pos;
   logic              row_dropped;
   logic [4:0]        col_setting;
   column_sum_type    sums_due [$];
   int                faults = 0;

   function automatic int used_columns(input logic [4:0] setting);
      if (setting == 5'd0) return 1;
      if (setting > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(setting);
   endfunction

   task automatic clear_row();
      for (int j = 0; j < MAX_COLUMNS; j++) col_acc[j] = '0;
      elem_pos    = '0;
      row_dropped = 1'b0;
   endtask

   // one activation element: MAC into every active column, emit sums on row end
   task automatic take_element(input logic signed [7:0] act, input logic row_end);
      int                 n;
      logic signed [31:0] prod;
      column_sum_type     s;
      n = used_columns(col_setting);
      if (elem_pos < MAX_DEPTH) begin
         for (int j = 0; j < n; j++) begin
            prod       = 32'(act) * 32'(weight_mem[j][elem_pos]);
            col_acc[j] = col_acc[j] + prod;
         end
         elem_pos = elem_pos + 1'b1;
      end else begin
         row_dropped = 1'b1;
      end
      if (row_end) begin
         for (int j = 0; j < n; j++) begin
            s.dot_sum        = col_acc[j];
            s.column_index   = j[3:0];
            s.final_column   = (j == n - 1);
            s.depth_overflow = row_dropped;
            sums_due.push_back(s);
         end
         clear_row();
      end
   endtask

   task automatic flag_fault(input string what, input column_sum_type want,
                             input column_sum_type got);
      if (faults < REPORT_LIMIT)
         $display("%s: expected sum %0d col %0d final %0b ovf %0b, %s %0d col %0d %s %0b %s %0b",
                  what, want.dot_sum, want.column_index, want.final_column,
                  want.depth_overflow, "got sum", got.dot_sum, got.column_index,
                  "final", got.final_column, "ovf", got.depth_overflow);
      faults++;
   endtask

   always @(posedge clock) begin
      column_sum_type got, want;
      if (reset) begin
         clear_row();
         col_setting = COLS_RESET;
         sums_due.delete();
      end else begin
         // responses first, so a beat pushed at this edge cannot hide a stray sum
         if (rsp_valid && rsp_ready) begin
            got = {rsp_dot_sum, rsp_column_index, rsp_final_column, rsp_depth_overflow};
            if (sums_due.size() == 0) begin
               flag_fault("unexpected sum", '0, got);
            end else begin
               want = sums_due.pop_front();
               if (got !== want) flag_fault("sum mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            if (req_action == ACTION_WEIGHT)
               weight_mem[req_weight_column][req_weight_position] = req_element_value;
            else
               take_element(req_element_value, req_row_end);
         end
         if (csr_write_enable) col_setting = csr_write_data;
      end
      sums_pending <= sums_due.size();
      fault_count  <= faults;
   end

endmodule

// ----- tb/tb_int8_matrix_vector_mac_unit.sv -----
module tb_int8_matrix_vector_mac_unit;
   import i8mvm_pkg::*;
   import i8mvm_tb_pkg::*;

   // Cycles to let the cell chain empty before touching the column count:
   // a beat walks the chain through one cell per column.
   localparam int SETTLE     = MAX_COLUMNS + 8;
   // Rows in the random part stay within the positions preloaded for every column.
   localparam int SHORT_ROW  = 16;
   localparam int RAND_ITEMS = 130;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic [3:0]         req_weight_column;
   logic [7:0]         req_weight_position;
   logic signed [7:0]  req_element_value;
   logic               req_row_end;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_dot_sum;
   logic [3:0]         rsp_column_index;
   logic               rsp_final_column;
   logic               rsp_depth_overflow;
   logic               csr_write_enable;
   logic [4:0]         csr_write_data;
   int                 sums_pending;
   int                 fault_count;

   // when set, the request side sends back to back
   bit                 burst;
   int                 rand_items;

   int8_matrix_vector_mac_unit u_top (.*);

   i8mvm_checker u_checker (.*);

   always #10 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Element values lean on the int8 extremes.
   function automatic logic [7:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h80;
      if (r < 20) return 8'h7f;
      if (r < 25) return 8'h00;
      if (r < 28) return 8'hff;
      return 8'($urandom);
   endfunction

   // Receiver: runs of ready broken by stalls, sometimes a long open stretch.
   initial begin
      int unsigned run;
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                           : $urandom_range(1, 20);
         repeat (run) @(negedge clock) rsp_ready <= 1'b1;
         stall = idle_cycles();
         repeat (stall) @(negedge clock) rsp_ready <= 1'b0;
      end
   end

   task automatic pause(input int unsigned n);
      repeat (n) @(negedge clock) req_valid <= 1'b0;
   endtask

   // Drive one beat at the falling edge and hold it until it is taken.
   // Valid stays up into the next beat unless an idle gap is drawn.
   task automatic send_beat(input action_type act, input logic [3:0] col,
                            input logic [7:0] pos, input logic [7:0] val,
                            input logic row_end);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_action          <= act;
      req_weight_column   <= col;
      req_weight_position <= pos;
      req_element_value   <= val;
      req_row_end         <= row_end;
      do @(posedge clock); while (!req_ready);
      rand_items++;
      if (!burst) pause(idle_cycles());
   endtask

   task automatic load_weight(input logic [3:0] col, input logic [7:0] pos,
                              input logic [7:0] val);
      // row_end rides along at random: it must be ignored on weight beats
      send_beat(ACTION_WEIGHT, col, pos, val, 1'($urandom));
   endtask

   // Column and position are don't-care on an element beat; keep them noisy.
   task automatic send_element(input logic [7:0] val, input logic row_end);
      send_beat(ACTION_ELEMENT, 4'($urandom), 8'($urandom), val, row_end);
   endtask

   task automatic send_row(input int len);
      for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
   endtask

   // Column count changes only with the chain empty and no sum outstanding;
   // mid-row is allowed, the partial sums stay in the accumulators.
   task automatic set_columns(input logic [4:0] value);
      @(negedge clock) req_valid <= 1'b0;
      while (sums_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned r;
      int          len;
      logic [4:0]  cols;

      clock               = 1'b0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_action          = ACTION_WEIGHT;
      req_weight_column   = '0;
      req_weight_position = '0;
      req_element_value   = '0;
      req_row_end         = 1'b0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      burst               = 1'b0;
      rand_items          = 0;

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // ---- weight preload ----
      // Column 0 gets the full depth (for the overflow row), every other column
      // the first SHORT_ROW positions. Nothing later reads outside these, so no
      // unwritten weight is ever used. Positions 0 and 1 hold the int8 extremes.
      burst = 1'b1;
      for (int p = 0; p < MAX_DEPTH; p++)
         load_weight(4'd0, 8'(p), (p == 0) ? 8'h80 : (p == 1) ? 8'h7f : 8'($urandom));
      for (int c = 1; c < MAX_COLUMNS; c++)
         for (int p = 0; p < SHORT_ROW; p++)
            load_weight(4'(c), 8'(p), (p == 0) ? 8'h80 : (p == 1) ? 8'h7f : 8'($urandom));
      burst = 1'b0;

      // ---- directed rows ----
      set_columns(5'd16);
      // extreme products: -128 * -128 and 127 * 127, then the mixed signs
      send_element(8'h80, 1'b0);
      send_element(8'h7f, 1'b1);
      send_element(8'h7f, 1'b0);
      send_element(8'h80, 1'b0);
      send_element(8'h00, 1'b1);
      // single-element row
      send_element(8'h80, 1'b1);

      // zero columns is treated as one
      set_columns(5'd0);
      send_row(2);
      // above the maximum is clamped to all columns
      set_columns(5'd31);
      send_row(3);

      // depth overflow: fill every position, then two dropped elements,
      // the second one closing the row
      set_columns(5'd1);
      burst = 1'b1;
      for (int i = 0; i < MAX_DEPTH; i++) send_element(pick_value(), 1'b0);
      burst = 1'b0;
      send_element(pick_value(), 1'b0);
      send_element(pick_value(), 1'b1);

      // column count changed mid-row: the sums use the count at the row end
      set_columns(5'd4);
      send_row_part: begin
         send_element(pick_value(), 1'b0);
         send_element(pick_value(), 1'b0);
      end
      set_columns(5'd9);
      send_element(pick_value(), 1'b0);
      send_element(pick_value(), 1'b1);
      set_columns(5'd17);
      send_row(1);

      // ---- random part ----
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // mostly the edges, sometimes a random count
            case ($urandom_range(0, 4))
               0: cols = 5'd0;
               1: cols = 5'd1;
               2: cols = 5'd16;
               3: cols = 5'd31;
               default: cols = 5'($urandom);
            endcase
            set_columns(cols);
         end else if (r < 22) begin
            // stray weight load anywhere; it only ever adds written entries
            load_weight(4'($urandom), 8'($urandom), pick_value());
         end else begin
            burst = ($urandom_range(0, 4) == 0);
            len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                : $urandom_range(1, SHORT_ROW);
            for (int i = 0; i < len; i++) begin
               // weight loads and count changes may land inside a row
               if ($urandom_range(0, 19) == 0)
                  load_weight(4'($urandom), 8'($urandom), pick_value());
               if ($urandom_range(0, 29) == 0)
                  set_columns(5'($urandom));
               send_element(pick_value(), i == len - 1);
            end
            burst = 1'b0;
         end
      end

      // ---- drain ----
      @(negedge clock) req_valid <= 1'b0;
      while (sums_pending != 0) @(negedge clock);
      repeat (2 * SETTLE) @(negedge clock);

      if (fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/i8mvm_pkg.sv
design/i8mvm_cell.sv
design/int8_matrix_vector_mac_unit.sv
tb/i8mvm_tb_pkg.sv
tb/i8mvm_checker.sv
tb/tb_int8_matrix_vector_mac_unit.sv
